### hdl/esckd_pkg.sv
// shared constants and types for the escape sequence key decoder
`default_nettype none

package esckd_pkg;

	localparam int unsigned REG_COUNT = 6;
	localparam int unsigned SEQ_BYTES = 8;
	localparam int unsigned POS_W = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned SEQ_W = 64;
	localparam int unsigned CODE_W = 9;

	localparam logic [7:0] ESC_BYTE = 8'h1b;

	localparam logic [CODE_W-1:0] SPECIAL_CODE [REG_COUNT] = '{
		9'h148, 9'h150, 9'h14b, 9'h14d, 9'h15e, 9'h160
	};

	localparam logic [SEQ_W-1:0] SEQ_RESET [REG_COUNT] = '{
		64'h0000_0000_0041_5b1b,
		64'h0000_0000_0042_5b1b,
		64'h0000_0000_0044_5b1b,
		64'h0000_0000_0043_5b1b,
		64'h0000_0000_0000_3c1b,
		64'h0000_0000_0000_3e1b
	};

	typedef struct packed {
		logic adv;
		logic done;
	} lane_stat_t;

endpackage

`default_nettype wire

### hdl/esckd_lane.sv
// compare of one input byte against the next expected byte of one sequence
`default_nettype none

module esckd_lane (
	input  wire logic [esckd_pkg::SEQ_W-1:0] seq,
	input  wire logic [esckd_pkg::POS_W-1:0] pos,
	input  wire logic [7:0]                  byte_val,
	output esckd_pkg::lane_stat_t            stat
);

	logic [2:0]                  pos_lo;
	logic [2:0]                  pos_inc;
	logic [esckd_pkg::SEQ_W-1:0] cur_sh;
	logic [esckd_pkg::SEQ_W-1:0] nxt_sh;
	logic [7:0]                  exp_byte;
	logic [7:0]                  nxt_byte;

	assign pos_lo  = pos[2:0];
	assign pos_inc = pos_lo + 3'd1;
	assign cur_sh  = seq >> {pos_lo, 3'b000};
	assign nxt_sh  = seq >> {pos_inc, 3'b000};
	// position eight means the whole register has matched
	assign exp_byte = pos[3] ? 8'h00 : cur_sh[7:0];
	assign nxt_byte = nxt_sh[7:0];

	always_comb begin
		stat.adv  = (exp_byte != 8'h00) && (exp_byte == byte_val);
		stat.done = stat.adv && ((pos_lo == 3'd7) || (nxt_byte == 8'h00));
	end

endmodule

`default_nettype wire

### hdl/escape_sequence_key_decoder.sv
// top level: byte input register, sequence match state, result register
// a byte taken in goes to the input register; its result then goes to the result register
// throughput: one byte per cycle; in_ready drops only while both registers are full
//   and out_ready is low
// bytes that extend an open sequence without completing it give no result
// reset: arst_n clears the match state and both valid flags and loads the
//   default sequences (ESC [ A/B/D/C, ESC <, ESC >)
`default_nettype none

module escape_sequence_key_decoder #(
	parameter int unsigned NUM_SEQUENCES = 6,
	parameter int unsigned ROUND_LIMIT   = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        byte_in,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [esckd_pkg::CODE_W-1:0]           key_code,
	output logic                                   is_special,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [esckd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [esckd_pkg::SEQ_W-1:0]       cfg_data
);

	localparam int unsigned NUM_ACT = (NUM_SEQUENCES > esckd_pkg::REG_COUNT) ?
		esckd_pkg::REG_COUNT : NUM_SEQUENCES;
	localparam int unsigned RND_W = $clog2(ROUND_LIMIT + 1);

	logic [esckd_pkg::SEQ_W-1:0]                 seq_q [NUM_ACT];
	logic [NUM_ACT-1:0][esckd_pkg::POS_W-1:0]    pos_q;
	logic [NUM_ACT-1:0][esckd_pkg::POS_W-1:0]    nxt_pos;
	logic                                        esc_q;
	logic                                        nxt_esc;
	logic [RND_W-1:0]                            rnd_q;
	logic [RND_W-1:0]                            nxt_rnd;

	logic                                        v_s1;
	logic [7:0]                                  byte_s1;
	logic                                        adv_s1;
	logic                                        proc_s1;

	logic                                        out_valid_q;
	logic [esckd_pkg::CODE_W-1:0]                key_code_q;
	logic                                        is_special_q;

	esckd_pkg::lane_stat_t                       stat [NUM_ACT];
	logic                                        any_adv;
	logic                                        any_done;
	logic [esckd_pkg::CODE_W-1:0]                sel_code;

	logic                                        res_v;
	logic [esckd_pkg::CODE_W-1:0]                res_code;
	logic                                        res_spec;

	assign cfg_ready  = 1'b1;
	assign adv_s1     = !out_valid_q || out_ready;
	assign proc_s1    = v_s1 && adv_s1;
	assign in_ready   = !v_s1 || adv_s1;
	assign out_valid  = out_valid_q;
	assign key_code   = key_code_q;
	assign is_special = is_special_q;

	for (genvar g = 0; g < NUM_ACT; g++) begin : g_lane
		esckd_lane u_lane (
			.seq      (seq_q[g]),
			.pos      (pos_q[g]),
			.byte_val (byte_s1),
			.stat     (stat[g])
		);
	end

	always_comb begin
		any_adv  = 1'b0;
		any_done = 1'b0;
		sel_code = '0;
		// descending so the lowest completed register wins
		for (int i = NUM_ACT - 1; i >= 0; i--) begin
			if (stat[i].adv) begin
				any_adv = 1'b1;
			end
			if (stat[i].done) begin
				any_done = 1'b1;
				sel_code = esckd_pkg::SPECIAL_CODE[i];
			end
		end
	end

	always_comb begin
		res_v    = 1'b0;
		res_code = {1'b0, byte_s1};
		res_spec = 1'b0;
		nxt_esc  = 1'b0;
		nxt_rnd  = '0;
		nxt_pos  = '0;
		if (!esc_q && (byte_s1 != esckd_pkg::ESC_BYTE)) begin
			res_v = 1'b1;
		end else if (esc_q && (rnd_q >= RND_W'(ROUND_LIMIT))) begin
			res_v = 1'b1;
		end else if (any_done) begin
			res_v    = 1'b1;
			res_code = sel_code;
			res_spec = 1'b1;
		end else if (!any_adv) begin
			// nothing moved: drop the prefix, pass the byte
			res_v = 1'b1;
		end else begin
			nxt_esc = 1'b1;
			nxt_rnd = rnd_q + RND_W'(1);
			for (int i = 0; i < NUM_ACT; i++) begin
				nxt_pos[i] = stat[i].adv ? pos_q[i] + esckd_pkg::POS_W'(1) : pos_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			esc_q       <= 1'b0;
			rnd_q       <= '0;
			pos_q       <= '0;
			for (int i = 0; i < NUM_ACT; i++) begin
				seq_q[i] <= esckd_pkg::SEQ_RESET[i];
			end
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s1) begin
				out_valid_q <= proc_s1 && res_v;
			end
			if (proc_s1) begin
				esc_q <= nxt_esc;
				rnd_q <= nxt_rnd;
				pos_q <= nxt_pos;
			end
			if (cfg_valid && cfg_ready) begin
				for (int i = 0; i < NUM_ACT; i++) begin
					if (cfg_index == esckd_pkg::CFG_IDX_W'(i)) begin
						seq_q[i] <= cfg_data;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
		end
		if (proc_s1 && res_v) begin
			key_code_q   <= res_code;
			is_special_q <= res_spec;
		end
	end

`ifndef SYNTHESIS
	a_idle_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!esc_q |-> (pos_q == '0))
		else $error("match position nonzero while idle");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= RND_W'(ROUND_LIMIT))
		else $error("round count past limit");

	a_special_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_special) |-> key_code[esckd_pkg::CODE_W-1])
		else $error("special result without special code");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> (v_s1 && $stable(byte_s1)))
		else $error("input stage lost a stalled byte");
`endif

endmodule

`default_nettype wire
